>>> hw/rtl/egw_pkg.sv
// ----------------------------------------------------------------------------
// egw_pkg
// Shared types and constants of the Exp-Golomb bit writer: opcodes, queue
// entry layout and queue status.
// ----------------------------------------------------------------------------
package egw_pkg;

	localparam int unsigned EGW_QUEUE_DEPTH = 4;
	localparam int unsigned INFO_W          = 33;
	localparam int unsigned CODE_W          = 2 * INFO_W - 1;
	localparam int unsigned LEN_W           = $clog2(CODE_W + 1);
	localparam int unsigned IDX_W           = $clog2(INFO_W);
	localparam int unsigned MAX_PUT_BITS    = 32;
	localparam int unsigned CAP_W           = 16;

	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_PUT_BITS = 3'd1,
		OP_PUT_UE   = 3'd2,
		OP_PUT_SE   = 3'd3,
		OP_TRAILING = 3'd4
	} egw_op_t;

	typedef enum logic [1:0] {
		KIND_BITS  = 2'd0,
		KIND_START = 2'd1,
		KIND_PAD   = 2'd2
	} egw_kind_t;

	typedef struct packed {
		egw_kind_t           kind;
		logic [CODE_W-1:0]   code;
		logic [LEN_W-1:0]    len;
	} egw_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} egw_qstat_t;

endpackage

>>> hw/rtl/egw_front.sv
// ----------------------------------------------------------------------------
// egw_front
// Two-stage front end: decodes the opcode, forms codeNum + 1 and the code
// length, then left-aligns the code for the packer queue.
// ----------------------------------------------------------------------------
module egw_front import egw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        opcode,
	input  logic [31:0]       value,
	input  logic [5:0]        bit_count,
	output logic              push_valid,
	output egw_entry_t        push_entry,
	input  egw_qstat_t        q_stat
);

	function automatic logic [IDX_W-1:0] msb_index(input logic [INFO_W-1:0] x);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < INFO_W; i++) begin
			if (x[i]) idx = IDX_W'(i);
		end
		return idx;
	endfunction

	logic              v_s1;
	logic              v_s2;
	egw_kind_t         kind_s1;
	egw_kind_t         kind_s2;
	logic              golomb_s1;
	logic [INFO_W-1:0] info_s1;
	logic [INFO_W-1:0] info_s2;
	logic [LEN_W-1:0]  len_s1;
	logic [LEN_W-1:0]  len_s2;

	egw_kind_t         kind_d;
	logic              golomb_d;
	logic [INFO_W-1:0] info_d;
	logic [LEN_W-1:0]  len_d;
	logic [INFO_W-1:0] ue_sum;
	logic [31:0]       mag;
	logic              se_low;
	logic [LEN_W-1:0]  len_e;
	logic              adv_s1;
	logic              adv_s2;

	assign adv_s2   = !v_s2 || !q_stat.full;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_comb begin
		kind_d   = KIND_BITS;
		golomb_d = 1'b0;
		info_d   = '0;
		len_d    = '0;
		ue_sum   = {1'b0, value} + INFO_W'(1);
		mag      = value[31] ? (~value + 32'd1) : value;
		se_low   = value[31] || (value == 32'd0);
		unique case (egw_op_t'(opcode))
			OP_START: begin
				kind_d = KIND_START;
			end
			OP_PUT_BITS: begin
				info_d = INFO_W'(value);
				len_d  = ({1'b0, bit_count} > LEN_W'(MAX_PUT_BITS)) ?
				         LEN_W'(MAX_PUT_BITS) : {1'b0, bit_count};
			end
			OP_PUT_UE: begin
				golomb_d = 1'b1;
				info_d   = ue_sum;
			end
			OP_PUT_SE: begin
				golomb_d = 1'b1;
				info_d   = {mag, se_low};
			end
			OP_TRAILING: begin
				kind_d = KIND_PAD;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			kind_s1   <= kind_d;
			golomb_s1 <= golomb_d;
			info_s1   <= info_d;
			len_s1    <= len_d;
		end
		if (adv_s2 && v_s1) begin
			kind_s2 <= kind_s1;
			info_s2 <= info_s1;
			len_s2  <= golomb_s1 ? LEN_W'({msb_index(info_s1), 1'b1}) : len_s1;
		end
	end

	assign len_e = (kind_s2 == KIND_BITS) ? len_s2 : '0;

	always_comb begin
		push_valid      = v_s2;
		push_entry.kind = kind_s2;
		push_entry.len  = len_e;
		if (kind_s2 == KIND_PAD) begin
			push_entry.code = {1'b1, {(CODE_W-1){1'b0}}};
		end else begin
			push_entry.code = CODE_W'(info_s2) << (LEN_W'(CODE_W) - len_e);
		end
	end

endmodule

>>> hw/rtl/egw_queue.sv
// ----------------------------------------------------------------------------
// egw_queue
// Short FIFO of decoded codes between the front end and the packer.
// ----------------------------------------------------------------------------
module egw_queue import egw_pkg::*; #(
	parameter int unsigned DEPTH = EGW_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  egw_entry_t push_entry,
	input  logic       pop,
	output egw_entry_t head_entry,
	output egw_qstat_t q_stat
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	egw_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire;

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign push_fire    = push_valid && !q_stat.full;
	assign head_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push_fire && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push_fire && pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

>>> hw/rtl/egw_back.sv
// ----------------------------------------------------------------------------
// egw_back
// Bit packer: merges queued codes into the byte in progress, one byte per
// cycle while the output is free; completed bytes wait in the output register.
// ----------------------------------------------------------------------------
module egw_back import egw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  egw_qstat_t       q_stat,
	input  egw_entry_t       head_entry,
	output logic             pop,
	input  logic [CAP_W-1:0] buffer_capacity,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic [15:0]      byte_index,
	output logic             last_of_run
);

	logic              cur_valid_q;
	egw_kind_t         cur_kind_q;
	logic [CODE_W-1:0] cur_code_q;
	logic [LEN_W-1:0]  cur_rem_q;
	logic [7:0]        partial_q;
	logic [2:0]        bit_pos_q;
	logic [15:0]       byte_count_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [15:0]       byte_index_q;
	logic              last_q;

	logic [3:0]        space;
	logic [LEN_W-1:0]  eff_rem;
	logic [3:0]        take;
	logic [LEN_W-1:0]  rest;
	logic [7:0]        chunk;
	logic [7:0]        merged;
	logic              cap_full;
	logic              out_free;
	logic              fills;
	logic              last_d;
	logic              step_ok;
	logic              done;
	logic              emit;
	logic              cur_finish;

	always_comb begin
		space    = 4'd8 - {1'b0, bit_pos_q};
		eff_rem  = (cur_kind_q == KIND_PAD) ? LEN_W'(space) : cur_rem_q;
		take     = (eff_rem < LEN_W'(space)) ? eff_rem[3:0] : space;
		rest     = eff_rem - LEN_W'(take);
		chunk    = cur_code_q[CODE_W-1 -: 8] >> (4'd8 - take);
		merged   = partial_q | (chunk << (space - take));
		cap_full = (byte_count_q >= buffer_capacity);
		out_free = !out_valid_q || !out_stall;
		fills    = (take == space);
		last_d   = (rest < LEN_W'(8)) ||
		           (({1'b0, byte_count_q} + 17'd1) >= {1'b0, buffer_capacity});
		step_ok  = 1'b0;
		done     = 1'b0;
		emit     = 1'b0;
		if (cur_valid_q) begin
			if (cur_kind_q == KIND_START || cap_full) begin
				step_ok = 1'b1;
				done    = 1'b1;
			end else if (fills) begin
				step_ok = out_free;
				emit    = out_free;
				done    = (rest == '0);
			end else begin
				step_ok = 1'b1;
				done    = (rest == '0);
			end
		end
		cur_finish = step_ok && done;
		pop        = !q_stat.empty && (!cur_valid_q || cur_finish);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q  <= 1'b0;
			partial_q    <= '0;
			bit_pos_q    <= '0;
			byte_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (cur_finish) begin
				cur_valid_q <= 1'b0;
			end
			if (cur_valid_q && step_ok) begin
				if (cur_kind_q == KIND_START) begin
					partial_q    <= '0;
					bit_pos_q    <= '0;
					byte_count_q <= '0;
				end else if (!cap_full) begin
					if (fills) begin
						partial_q    <= '0;
						bit_pos_q    <= '0;
						byte_count_q <= byte_count_q + 16'd1;
					end else begin
						partial_q <= merged;
						bit_pos_q <= bit_pos_q + take[2:0];
					end
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_kind_q <= head_entry.kind;
			cur_code_q <= head_entry.code;
			cur_rem_q  <= head_entry.len;
		end else if (cur_valid_q && step_ok && !done) begin
			cur_code_q <= cur_code_q << take;
			cur_rem_q  <= rest;
		end
		if (emit) begin
			out_byte_q   <= merged;
			byte_index_q <= byte_count_q;
			last_q       <= last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign byte_index  = byte_index_q;
	assign last_of_run = last_q;

endmodule

>>> hw/rtl/exp_golomb_bit_writer.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer
// MSB-first bitstream packer with raw, ue, se and trailing-bit operations.
// ----------------------------------------------------------------------------
// One item is taken per cycle while in_stall is low. The front end decodes an
// item through its s1 and s2 registers and forms its left-aligned code, then
// hands it to a short queue. The packer behind the queue completes at most
// one byte per cycle while the output is not stalled, so an item holds the
// packer for each byte that it finishes (up to 9 for the widest se code) and
// for a further step when leftover bits remain or when it finishes no byte.
// The queue absorbs short items that arrive while a long code is draining.
// An item's first byte passes s1, s2, the queue, the packer and out_byte_q.
module exp_golomb_bit_writer import egw_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = EGW_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [CAP_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       opcode,
	input  logic [31:0]      value,
	input  logic [5:0]       bit_count,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic [15:0]      byte_index,
	output logic             last_of_run
);

	logic [CAP_W-1:0] buffer_capacity_q;
	logic             push_valid;
	egw_entry_t       push_entry;
	egw_entry_t       head_entry;
	egw_qstat_t       q_stat;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_capacity_q <= '1;
		end else if (cfg_write) begin
			buffer_capacity_q <= cfg_data;
		end
	end

	egw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.value      (value),
		.bit_count  (bit_count),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.q_stat     (q_stat)
	);

	egw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.q_stat     (q_stat)
	);

	egw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_stat          (q_stat),
		.head_entry      (head_entry),
		.pop             (pop),
		.buffer_capacity (buffer_capacity_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.byte_index      (byte_index),
		.last_of_run     (last_of_run)
	);

`ifndef SYNTH
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty at once");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_full_drain: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |=> !q_stat.empty)
		else $error("queue went from full to empty in one cycle");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |=> !q_stat.full)
		else $error("queue went from empty to full in one cycle");
`endif

endmodule

>>> dv/tb_exp_golomb_bit_writer.sv
// ----------------------------------------------------------------------------
// tb_exp_golomb_bit_writer
// Self-checking bench for the Exp-Golomb bit writer. Directed tests cover
// raw, ue, se and trailing-bit operations at the field extremes, and the
// capacity limit. Random streams follow under three sender/receiver idle
// mixes. A bit-level packer model predicts every output byte with its index
// and end-of-item mark. The checker compares each output transfer against
// that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_exp_golomb_bit_writer;
	import egw_pkg::*;

	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] index;
		logic        last_mark;
	} out_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [CAP_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        opcode = '0;
	logic [31:0]       value = '0;
	logic [5:0]        bit_count = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        out_byte;
	logic [15:0]       byte_index;
	logic              last_of_run;

	int unsigned       tx_idle_pct = 0;
	int unsigned       rx_idle_pct = 0;
	int                fail_count = 0;

	// packer model state
	logic [7:0]        pk_partial;
	int                pk_fill;
	logic [15:0]       pk_count;
	logic [CAP_W-1:0]  pk_capacity;
	out_byte_t         held_byte;
	bit                have_held;
	out_byte_t         expected_bytes[$];

	exp_golomb_bit_writer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.value       (value),
		.bit_count   (bit_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_index  (byte_index),
		.last_of_run (last_of_run)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall = arst_n && ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		out_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected transfer: out_byte %02h byte_index %0d last_of_run %0b",
					out_byte, byte_index, last_of_run);
				fail_count++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte: expected %02h, actual %02h", want.data, out_byte);
					fail_count++;
				end
				if (byte_index !== want.index) begin
					$error("byte_index: expected %0d, actual %0d", want.index, byte_index);
					fail_count++;
				end
				if (last_of_run !== want.last_mark) begin
					$error("last_of_run: expected %0b, actual %0b", want.last_mark,
						last_of_run);
					fail_count++;
				end
			end
		end
	end

	task automatic pack_bit(input logic b);
		if (pk_count >= pk_capacity)
			return;
		if (b)
			pk_partial[7 - pk_fill] = 1'b1;
		pk_fill++;
		if (pk_fill == 8) begin
			if (have_held)
				expected_bytes.push_back(held_byte);
			held_byte = '{data: pk_partial, index: pk_count, last_mark: 1'b0};
			have_held = 1'b1;
			pk_count = pk_count + 16'd1;
			pk_fill = 0;
			pk_partial = '0;
		end
	endtask

	task automatic pack_ue(input logic [32:0] code_num);
		logic [33:0] v;
		int          n;
		v = {1'b0, code_num} + 34'd1;
		n = 0;
		for (int i = 0; i < 34; i++)
			if (v[i])
				n = i;
		repeat (n) pack_bit(1'b0);
		for (int i = n; i >= 0; i--)
			pack_bit(v[i]);
	endtask

	task automatic pack_item(input logic [2:0] op, input logic [31:0] val,
			input logic [5:0] cnt);
		int          n;
		logic [32:0] code_num;
		have_held = 1'b0;
		case (op)
			OP_START: begin
				pk_partial = '0;
				pk_fill = 0;
				pk_count = '0;
			end
			OP_PUT_BITS: begin
				n = (cnt > MAX_PUT_BITS) ? MAX_PUT_BITS : cnt;
				for (int i = n - 1; i >= 0; i--)
					pack_bit(val[i]);
			end
			OP_PUT_UE: pack_ue({1'b0, val});
			OP_PUT_SE: begin
				if (val[31])
					code_num = (33'h1_0000_0000 - {1'b0, val}) << 1;
				else if (val == '0)
					code_num = '0;
				else
					code_num = {val, 1'b0} - 33'd1;
				pack_ue(code_num);
			end
			OP_TRAILING: begin
				pack_bit(1'b1);
				for (int k = 0; k < 8 && pk_fill != 0 && pk_count < pk_capacity; k++)
					pack_bit(1'b0);
			end
			default: ;
		endcase
		if (have_held) begin
			held_byte.last_mark = 1'b1;
			expected_bytes.push_back(held_byte);
			have_held = 1'b0;
		end
	endtask

	// Entered and left just after a falling edge.
	task automatic send_item(input logic [2:0] op, input logic [31:0] val,
			input logic [5:0] cnt);
		bit accepted;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			opcode = 3'($urandom);
			value = $urandom;
			bit_count = 6'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		value = val;
		bit_count = cnt;
		accepted = 1'b0;
		while (!accepted) begin
			@(posedge clk);
			accepted = !in_stall;
		end
		pack_item(op, val, cnt);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_drained();
		cfg_write = 1'b1;
		cfg_data = cap;
		pk_capacity = cap;
		@(negedge clk);
		cfg_write = 1'b0;
		cfg_data = 16'($urandom);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0: pick_value = $urandom_range(0, 16);
			1: pick_value = $urandom;
			2: pick_value = $urandom >> $urandom_range(31);
			default: begin
				case ($urandom_range(3))
					0: pick_value = 32'h0000_0000;
					1: pick_value = 32'hFFFF_FFFF;
					2: pick_value = 32'h8000_0000;
					default: pick_value = 32'h7FFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic logic [CAP_W-1:0] pick_capacity();
		case ($urandom_range(3))
			0, 1: pick_capacity = 16'hFFFF;
			2: pick_capacity = CAP_W'($urandom_range(4, 40));
			default: pick_capacity = CAP_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic test_directed_ops();
		send_item(OP_START, 32'h0, 6'd0);
		send_item(OP_PUT_BITS, 32'hFFFF_FFFF, 6'd32);
		send_item(OP_PUT_BITS, 32'hFFFF_FFFF, 6'd0);
		send_item(OP_PUT_BITS, 32'hA5A5_A5A5, 6'd63);
		send_item(OP_PUT_BITS, 32'h0F0F_0F0F, 6'd33);
		send_item(OP_PUT_BITS, 32'h0000_0001, 6'd3);
		send_item(OP_PUT_UE, 32'h0, 6'd0);
		send_item(OP_PUT_UE, 32'h1, 6'd0);
		send_item(OP_PUT_UE, 32'hFFFF_FFFF, 6'd0);
		send_item(OP_PUT_SE, 32'h0, 6'd0);
		send_item(OP_PUT_SE, 32'h1, 6'd0);
		send_item(OP_PUT_SE, 32'hFFFF_FFFF, 6'd0);
		send_item(OP_PUT_SE, 32'h7FFF_FFFF, 6'd0);
		send_item(OP_PUT_SE, 32'h8000_0000, 6'd0);
		send_item(OP_TRAILING, 32'h0, 6'd0);
		send_item(OP_TRAILING, 32'hFFFF_FFFF, 6'd63);
		for (int op = OP_TRAILING + 1; op < 8; op++)
			send_item(3'(op), $urandom, 6'($urandom));
		send_item(OP_PUT_BITS, 32'h5, 6'd3);
		send_item(OP_START, 32'hFFFF_FFFF, 6'd63);
		send_item(OP_PUT_UE, 32'h7, 6'd0);
		send_item(OP_TRAILING, 32'h0, 6'd0);
	endtask

	task automatic test_capacity_zero();
		write_capacity(16'h0000);
		send_item(OP_START, 32'h0, 6'd0);
		send_item(OP_PUT_BITS, 32'hFFFF_FFFF, 6'd32);
		send_item(OP_PUT_UE, 32'hFFFF_FFFF, 6'd0);
		send_item(OP_PUT_SE, 32'h8000_0000, 6'd0);
		send_item(OP_TRAILING, 32'h0, 6'd0);
	endtask

	task automatic test_capacity_full();
		write_capacity(16'd2);
		send_item(OP_START, 32'h0, 6'd0);
		send_item(OP_PUT_SE, 32'h8000_0000, 6'd0);
		send_item(OP_TRAILING, 32'h0, 6'd0);
		send_item(OP_START, 32'h0, 6'd0);
		send_item(OP_PUT_BITS, 32'hB, 6'd4);
		send_item(OP_TRAILING, 32'h0, 6'd0);
		send_item(OP_PUT_BITS, 32'h1_2345, 6'd20);
		send_item(OP_TRAILING, 32'h0, 6'd0);
		send_item(OP_PUT_UE, 32'h3, 6'd0);
	endtask

	task automatic test_capacity_lowered_mid_byte();
		write_capacity(16'hFFFF);
		send_item(OP_START, 32'h0, 6'd0);
		send_item(OP_PUT_BITS, 32'hABC, 6'd12);
		write_capacity(16'd1);
		send_item(OP_PUT_BITS, 32'hFF, 6'd8);
		send_item(OP_TRAILING, 32'h0, 6'd0);
		send_item(OP_PUT_UE, 32'h5, 6'd0);
		write_capacity(16'hFFFF);
		send_item(OP_PUT_BITS, 32'h5, 6'd4);
		send_item(OP_TRAILING, 32'h0, 6'd0);
	endtask

	task automatic test_random_stream(input int items);
		int unsigned sel;
		logic [5:0]  cnt;
		write_capacity(pick_capacity());
		send_item(OP_START, $urandom, 6'($urandom));
		for (int i = 1; i < items; i++) begin
			sel = $urandom_range(99);
			cnt = ($urandom_range(99) < 15) ? 6'($urandom_range(33, 63))
				: 6'($urandom_range(0, 32));
			if (sel < 4)
				send_item(OP_START, $urandom, cnt);
			else if (sel < 8)
				send_item(3'(OP_TRAILING + $urandom_range(1, 3)), $urandom, cnt);
			else if (sel < 35)
				send_item(OP_PUT_BITS, pick_value(), cnt);
			else if (sel < 60)
				send_item(OP_PUT_UE, pick_value(), cnt);
			else if (sel < 85)
				send_item(OP_PUT_SE, pick_value(), cnt);
			else
				send_item(OP_TRAILING, $urandom, cnt);
		end
	endtask

	initial begin
		pk_partial = '0;
		pk_fill = 0;
		pk_count = '0;
		pk_capacity = 16'hFFFF;
		have_held = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 31;
		rx_idle_pct = 79;
		test_directed_ops();
		test_capacity_zero();
		test_capacity_full();
		test_capacity_lowered_mid_byte();
		repeat (3) test_random_stream(50);

		tx_idle_pct = 79;
		rx_idle_pct = 31;
		repeat (3) test_random_stream(50);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (3) test_random_stream(50);

		wait_drained();
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
